// ===== design/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the timing wheel scheduler
// Sizes of the wheel, field widths, codes and the structs passed between
// the front end, the engine and the result queue.
// ----------------------------------------------------------------------------
package tws_pkg;

   localparam int SLOTS         = 64;
   localparam int SLOT_CAPACITY = 16;

   localparam int CSR_W      = 7;
   localparam int HANDLE_W   = 16;
   localparam int DELAY_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int RSP_SLOT_W = 6;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
   localparam int ADDR_W = $clog2(SLOTS * SLOT_CAPACITY);

   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_TICK   = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED   = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_NO_ROOM  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REJECT = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type        cls;
      logic [HANDLE_W-1:0]  handle;
      logic [DELAY_W-1:0]   delay;
   } cmd_type;

   // front end to engine: head of the command queue
   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } cmd_src_type;

   typedef struct packed {
      kind_type              kind;
      status_type            status;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  fired_valid;
      logic [HANDLE_W-1:0]   fired_handle;
      logic                  last;
   } rsp_type;

   // engine to result queue: one result written per push
   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } rsp_push_type;

endpackage

// ===== design/tws_front.sv =====
// ----------------------------------------------------------------------------
// tws_front: request intake
// Holds the wheel size register, classifies each request and queues it
// for the engine.
// ----------------------------------------------------------------------------
module tws_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_op,
   input  logic [tws_pkg::HANDLE_W-1:0]     req_handle,
   input  logic [tws_pkg::DELAY_W-1:0]      req_delay,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tws_pkg::CSR_W-1:0]        csr_data,
   output logic [tws_pkg::CSR_W-1:0]        wheel_size,
   output tws_pkg::cmd_src_type             cmd_src,
   input  logic                             cmd_pop
);

   localparam int PTR_W  = (tws_pkg::CMDQ_DEPTH > 1) ? $clog2(tws_pkg::CMDQ_DEPTH) : 1;
   localparam int QCNT_W = $clog2(tws_pkg::CMDQ_DEPTH + 1);

   logic [tws_pkg::CSR_W-1:0] csr_ff, csr_in;
   tws_pkg::cmd_type          cmd_new;
   tws_pkg::cmd_type          q_mem [tws_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         cnt_ff, cnt_in;
   logic                      wr_en, rd_en;

   assign csr_ready = 1'b1;
   assign csr_in    = csr_valid ? csr_data : csr_ff;

   // clamp the register into the legal wheel range
   always_comb begin
      if (csr_ff < tws_pkg::CSR_W'(2)) begin
         wheel_size = tws_pkg::CSR_W'(2);
      end else if (csr_ff > tws_pkg::CSR_W'(tws_pkg::SLOTS)) begin
         wheel_size = tws_pkg::CSR_W'(tws_pkg::SLOTS);
      end else begin
         wheel_size = csr_ff;
      end
   end

   always_comb begin
      cmd_new.handle = req_handle;
      cmd_new.delay  = req_delay;
      if (tws_pkg::op_type'(req_op) == tws_pkg::OP_TICK) begin
         cmd_new.cls = tws_pkg::CMD_TICK;
      end else if (req_handle == '0 || req_delay == '0 ||
                   tws_pkg::CSR_W'(req_delay) >= wheel_size) begin
         cmd_new.cls = tws_pkg::CMD_REJECT;
      end else begin
         cmd_new.cls = tws_pkg::CMD_INSERT;
      end
   end

   assign full  = (cnt_ff == QCNT_W'(tws_pkg::CMDQ_DEPTH));
   assign wr_en = push && !full;
   assign rd_en = cmd_pop && (cnt_ff != '0);

   assign cmd_src.avail = (cnt_ff != '0);
   assign cmd_src.cmd   = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tws_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tws_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff    <= tws_pkg::CSR_W'(tws_pkg::SLOTS);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         csr_ff    <= csr_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== design/tws_engine.sv =====
// ----------------------------------------------------------------------------
// tws_engine: wheel engine
// Owns the slot store, per-slot fill counts and current pointer; carries
// out inserts (wrap scan) and ticks (one handle a cycle unless stalled).
// ----------------------------------------------------------------------------
module tws_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tws_pkg::CSR_W-1:0]     wheel_size,
   input  tws_pkg::cmd_src_type          cmd_src,
   output logic                          cmd_pop,
   output tws_pkg::rsp_push_type         rsp_src,
   input  logic                          rsp_full
);

   localparam int SW = tws_pkg::SLOT_W;
   localparam int NW = tws_pkg::CSR_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_TCHECK = 5'b00100,
      ST_TEMIT  = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   function automatic logic [tws_pkg::ADDR_W-1:0] entry_addr(
      input logic [SW-1:0]             slot,
      input logic [tws_pkg::IDX_W-1:0] idx
   );
      entry_addr = tws_pkg::ADDR_W'(slot) * tws_pkg::ADDR_W'(tws_pkg::SLOT_CAPACITY) +
                   tws_pkg::ADDR_W'(idx);
   endfunction

   state_type                        state_ff, state_in;
   logic [SW-1:0]                    cur_ff, cur_in, scan_ff, scan_in;
   logic [tws_pkg::HANDLE_W-1:0]     handle_ff, handle_in;
   logic [tws_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [tws_pkg::IDX_W-1:0]        idx_ff, idx_in;
   tws_pkg::rsp_type                 rsp_ff, rsp_in, tick_rsp;
   logic [tws_pkg::SLOTS-1:0]        valid_ff, valid_in;

   logic [tws_pkg::CNT_W-1:0]        count_mem [tws_pkg::SLOTS];
   logic [tws_pkg::CNT_W-1:0]        count_rd_ff;
   logic                             count_vld_ff;
   logic                             cnt_rd_en, cnt_wr_en;
   logic [SW-1:0]                    cnt_rd_addr;
   logic [tws_pkg::CNT_W-1:0]        cnt_wr_data;

   logic [tws_pkg::HANDLE_W-1:0]     store_mem [tws_pkg::SLOTS * tws_pkg::SLOT_CAPACITY];
   logic [tws_pkg::HANDLE_W-1:0]     store_rd_ff;
   logic                             st_rd_en, st_wr_en;
   logic [tws_pkg::ADDR_W-1:0]       st_rd_addr, st_wr_addr;

   logic [SW-1:0]                    cur_eff, s_first, scan_next, cur_next;
   logic [NW-1:0]                    sum;
   logic [tws_pkg::CNT_W-1:0]        cnt_eff;
   logic                             last_entry;
   logic                             offer;

   // pointer left beyond a shrunk wheel restarts at slot zero
   assign cur_eff   = (NW'(cur_ff) >= wheel_size) ? '0 : cur_ff;
   assign sum       = NW'(cur_eff) + NW'(cmd_src.cmd.delay);
   assign s_first   = (sum >= wheel_size) ? SW'(sum - wheel_size) : SW'(sum);
   assign scan_next = (NW'(scan_ff) + NW'(1) == wheel_size) ? '0 : scan_ff + 1'b1;
   assign cur_next  = (NW'(cur_ff) + NW'(1) == wheel_size) ? '0 : cur_ff + 1'b1;
   assign cnt_eff   = count_vld_ff ? count_rd_ff : '0;
   assign last_entry = (tws_pkg::CNT_W'(idx_ff) + tws_pkg::CNT_W'(1) == cnt_ff);

   always_comb begin
      tick_rsp.kind         = tws_pkg::KIND_TICK;
      tick_rsp.status       = tws_pkg::STATUS_STORED;
      tick_rsp.slot         = tws_pkg::RSP_SLOT_W'(scan_ff);
      tick_rsp.fired_valid  = 1'b1;
      tick_rsp.fired_handle = store_rd_ff;
      tick_rsp.last         = last_entry;
   end

   assign offer        = (state_ff == ST_REPLY) || (state_ff == ST_TEMIT);
   assign rsp_src.push = offer && !rsp_full;
   assign rsp_src.rsp  = (state_ff == ST_TEMIT) ? tick_rsp : rsp_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      scan_in     = scan_ff;
      handle_in   = handle_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      rsp_in      = rsp_ff;
      valid_in    = valid_ff;
      cmd_pop     = 1'b0;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = scan_ff;
      cnt_wr_en   = 1'b0;
      cnt_wr_data = cnt_eff + 1'b1;
      st_rd_en    = 1'b0;
      st_rd_addr  = entry_addr(scan_ff, idx_ff);
      st_wr_en    = 1'b0;
      st_wr_addr  = entry_addr(scan_ff, cnt_eff[tws_pkg::IDX_W-1:0]);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_src.avail) begin
               cur_in    = cur_eff;
               handle_in = cmd_src.cmd.handle;
               case (cmd_src.cmd.cls)
                  tws_pkg::CMD_REJECT: begin
                     cmd_pop             = 1'b1;
                     rsp_in.kind         = tws_pkg::KIND_INSERT;
                     rsp_in.status       = tws_pkg::STATUS_REJECTED;
                     rsp_in.slot         = '0;
                     rsp_in.fired_valid  = 1'b0;
                     rsp_in.fired_handle = '0;
                     rsp_in.last         = 1'b1;
                     state_in            = ST_REPLY;
                  end
                  tws_pkg::CMD_INSERT: begin
                     cmd_pop     = 1'b1;
                     scan_in     = s_first;
                     cnt_rd_en   = 1'b1;
                     cnt_rd_addr = s_first;
                     state_in    = ST_SCAN;
                  end
                  tws_pkg::CMD_TICK: begin
                     cmd_pop     = 1'b1;
                     scan_in     = cur_eff;
                     cnt_rd_en   = 1'b1;
                     cnt_rd_addr = cur_eff;
                     state_in    = ST_TCHECK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rsp_in.kind         = tws_pkg::KIND_INSERT;
            rsp_in.fired_valid  = 1'b0;
            rsp_in.fired_handle = '0;
            rsp_in.last         = 1'b1;
            if (cnt_eff < tws_pkg::CNT_W'(tws_pkg::SLOT_CAPACITY)) begin
               st_wr_en          = 1'b1;
               cnt_wr_en         = 1'b1;
               valid_in[scan_ff] = 1'b1;
               rsp_in.status     = tws_pkg::STATUS_STORED;
               rsp_in.slot       = tws_pkg::RSP_SLOT_W'(scan_ff);
               state_in          = ST_REPLY;
            end else if (scan_next == cur_ff) begin
               rsp_in.status = tws_pkg::STATUS_NO_ROOM;
               rsp_in.slot   = '0;
               state_in      = ST_REPLY;
            end else begin
               scan_in     = scan_next;
               cnt_rd_en   = 1'b1;
               cnt_rd_addr = scan_next;
            end
         end
         ST_TCHECK: begin
            if (cnt_eff == '0) begin
               rsp_in.kind         = tws_pkg::KIND_TICK;
               rsp_in.status       = tws_pkg::STATUS_STORED;
               rsp_in.slot         = tws_pkg::RSP_SLOT_W'(scan_ff);
               rsp_in.fired_valid  = 1'b0;
               rsp_in.fired_handle = '0;
               rsp_in.last         = 1'b1;
               cur_in              = cur_next;
               state_in            = ST_REPLY;
            end else begin
               cnt_in     = cnt_eff;
               idx_in     = '0;
               st_rd_en   = 1'b1;
               st_rd_addr = entry_addr(scan_ff, '0);
               state_in   = ST_TEMIT;
            end
         end
         ST_TEMIT: begin
            if (!rsp_full) begin
               if (last_entry) begin
                  valid_in[scan_ff] = 1'b0;
                  cur_in            = cur_next;
                  state_in          = ST_IDLE;
               end else begin
                  idx_in     = idx_ff + 1'b1;
                  st_rd_en   = 1'b1;
                  st_rd_addr = entry_addr(scan_ff, idx_ff + 1'b1);
               end
            end
         end
         ST_REPLY: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      handle_ff <= handle_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   // fill count memory; a slot whose valid bit is clear counts as empty
   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         count_mem[scan_ff] <= cnt_wr_data;
      end
      if (cnt_rd_en) begin
         count_rd_ff  <= count_mem[cnt_rd_addr];
         count_vld_ff <= valid_ff[cnt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         store_mem[st_wr_addr] <= handle_ff;
      end
      if (st_rd_en) begin
         store_rd_ff <= store_mem[st_rd_addr];
      end
   end

endmodule

// ===== design/tws_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// tws_rsp_queue: result queue
// Small FIFO that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module tws_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tws_pkg::rsp_push_type  rsp_src,
   output logic                   rsp_full,
   output logic                   empty,
   input  logic                   pop,
   output tws_pkg::rsp_type       rsp_head
);

   localparam int PTR_W  = (tws_pkg::RSPQ_DEPTH > 1) ? $clog2(tws_pkg::RSPQ_DEPTH) : 1;
   localparam int QCNT_W = $clog2(tws_pkg::RSPQ_DEPTH + 1);

   tws_pkg::rsp_type  q_mem [tws_pkg::RSPQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              wr_en, rd_en;

   assign rsp_full = (cnt_ff == QCNT_W'(tws_pkg::RSPQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign wr_en    = rsp_src.push && !rsp_full;
   assign rd_en    = pop && !empty;
   assign rsp_head = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tws_pkg::RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tws_pkg::RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[wr_ptr_ff] <= rsp_src.rsp;
      end
   end

endmodule

// ===== design/timing_wheel_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_core: single-level timing wheel
// Requests in through a queue-style push port, results out through a
// queue-style pop port, wheel size through its own write channel.
// ----------------------------------------------------------------------------
// A single-level timing wheel of up to 64 slots with 16 handles per slot.
// An insert request (op 0) stores a nonzero handle in slot
// (current + delay) mod slots_in_use, moving on to later slots (wrapping,
// never reaching the current slot) while a slot is full; it always gives
// exactly one reply. A tick request (op 1) fires the current slot: one
// result per stored handle in insertion order with last on the final one,
// or one result with fired_valid low on an empty slot, then advances the
// pointer. Requests are handled one at a time by the engine: a rejected
// insert goes straight to its reply; an insert scans slots, reading one fill
// count a cycle, until it stores the handle or finds no room, then replies;
// a tick reads the current slot's fill count, then emits one result per
// fired handle (the slot store streams one handle a cycle while the result
// queue has room) or one reply on an empty slot. A two-entry request queue
// in front and a two-entry result queue behind let the producer and
// consumer stall independently. No clearing pass follows reset: per-slot
// valid bits mark every slot empty at once. Write slots_in_use only while
// the block is idle; values below 2 act as 2 and above 64 act as 64.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_core (
   input  logic                              clock,
   input  logic                              reset,
   // request side
   input  logic                              push,
   output logic                              full,
   input  logic                              req_op,
   input  logic [tws_pkg::HANDLE_W-1:0]      req_handle,
   input  logic [tws_pkg::DELAY_W-1:0]       req_delay,
   // result side
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_kind,
   output logic [tws_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tws_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   output logic                              rsp_fired_valid,
   output logic [tws_pkg::HANDLE_W-1:0]      rsp_fired_handle,
   output logic                              rsp_last,
   // wheel size register
   input  logic                              valid,
   output logic                              ready,
   input  logic [tws_pkg::CSR_W-1:0]         csr_data
);

   logic [tws_pkg::CSR_W-1:0] wheel_size;
   tws_pkg::cmd_src_type      cmd_src;
   logic                      cmd_pop;
   tws_pkg::rsp_push_type     rsp_src;
   logic                      rsp_full;
   tws_pkg::rsp_type          rsp_head;

   // classify and queue requests; hold the wheel size register
   tws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_op     (req_op),
      .req_handle (req_handle),
      .req_delay  (req_delay),
      .csr_valid  (valid),
      .csr_ready  (ready),
      .csr_data   (csr_data),
      .wheel_size (wheel_size),
      .cmd_src    (cmd_src),
      .cmd_pop    (cmd_pop)
   );

   // carry out inserts and ticks against the slot memories
   tws_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .wheel_size (wheel_size),
      .cmd_src    (cmd_src),
      .cmd_pop    (cmd_pop),
      .rsp_src    (rsp_src),
      .rsp_full   (rsp_full)
   );

   // buffer results for the consumer
   tws_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_src  (rsp_src),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_head (rsp_head)
   );

   assign rsp_kind         = rsp_head.kind;
   assign rsp_status       = rsp_head.status;
   assign rsp_slot         = rsp_head.slot;
   assign rsp_fired_valid  = rsp_head.fired_valid;
   assign rsp_fired_handle = rsp_head.fired_handle;
   assign rsp_last         = rsp_head.last;

endmodule

// ===== design/tws_checker.sv =====
// ----------------------------------------------------------------------------
// tws_checker: port-level checks of the timing wheel scheduler
// Watches the result port for malformed results; bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              full,
   input logic                              empty,
   input logic                              pop,
   input logic                              rsp_kind,
   input logic [tws_pkg::STATUS_W-1:0]      rsp_status,
   input logic [tws_pkg::RSP_SLOT_W-1:0]    rsp_slot,
   input logic                              rsp_fired_valid,
   input logic [tws_pkg::HANDLE_W-1:0]      rsp_fired_handle,
   input logic                              rsp_last
);

   // no result may be waiting and no request refused right after reset
   a_empty_after_reset: assert property (
      @(posedge clock) reset |=> (empty && !full)
   ) else $error("result waiting or input full after reset");

   // hold a waiting result unchanged until it is popped
   a_hold_result: assert property (
      @(posedge clock) disable iff (reset)
      (!empty && !pop) |=>
         (!empty && $stable({rsp_kind, rsp_status, rsp_slot, rsp_fired_valid,
                             rsp_fired_handle, rsp_last}))
   ) else $error("waiting result changed before pop");

   // an insert gives exactly one reply, carrying no fired handle
   a_insert_single: assert property (
      @(posedge clock) disable iff (reset)
      (!empty && rsp_kind == tws_pkg::KIND_INSERT) |->
         (rsp_last && !rsp_fired_valid && rsp_fired_handle == '0)
   ) else $error("malformed insert reply");

   // a failed insert reports slot zero; ticks always report status zero
   a_status_slot: assert property (
      @(posedge clock) disable iff (reset)
      (!empty && rsp_status != tws_pkg::STATUS_STORED) |->
         (rsp_kind == tws_pkg::KIND_INSERT && rsp_slot == '0)
   ) else $error("bad status on result");

   // an empty tick is one result closing the request
   a_empty_tick: assert property (
      @(posedge clock) disable iff (reset)
      (!empty && rsp_kind == tws_pkg::KIND_TICK && !rsp_fired_valid) |->
         (rsp_last && rsp_fired_handle == '0)
   ) else $error("empty tick result malformed");

endmodule

bind timing_wheel_scheduler_core tws_checker u_tws_checker (
   .clock            (clock),
   .reset            (reset),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_kind         (rsp_kind),
   .rsp_status       (rsp_status),
   .rsp_slot         (rsp_slot),
   .rsp_fired_valid  (rsp_fired_valid),
   .rsp_fired_handle (rsp_fired_handle),
   .rsp_last         (rsp_last)
);
